>>> design/sdtq_pkg.sv
// shared types, codes and constants of the sorted deadline timer queue
package sdtq_pkg;

  // default sizing
  localparam int DEPTH_DEF   = 16;
  localparam int ID_BITS_DEF = 8;

  // fixed field widths and limits
  localparam int TIME_W    = 32;
  localparam int TASK_ID_W = 8;
  localparam int MAX_BURST = 16;
  localparam int CFG_IDX_W = 1;

  // request commands
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_DONE   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_EN    = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEAD = 1'd1;

  // scan index operations
  localparam logic [2:0] IDX_HOLD      = 3'd0;
  localparam logic [2:0] IDX_LOAD_TOP  = 3'd1;
  localparam logic [2:0] IDX_LOAD_ZERO = 3'd2;
  localparam logic [2:0] IDX_INC       = 3'd3;
  localparam logic [2:0] IDX_DEC       = 3'd4;

  // table write position relative to the scan index
  localparam logic [1:0] WPOS_IDX = 2'd0;
  localparam logic [1:0] WPOS_P1  = 2'd1;
  localparam logic [1:0] WPOS_M1  = 2'd2;

  // table write data source
  localparam logic WSEL_NEW = 1'b0;
  localparam logic WSEL_OLD = 1'b1;

  // result id source
  localparam logic [1:0] IDSEL_CMD  = 2'd0;
  localparam logic [1:0] IDSEL_PEND = 2'd1;
  localparam logic [1:0] IDSEL_ZERO = 2'd2;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [TASK_ID_W-1:0] task_id;
    logic [TIME_W-1:0]    delay;
    logic [TIME_W-1:0]    interval;
  } req_t;

  typedef struct packed {
    logic                 dispatch;
    logic [TASK_ID_W-1:0] out_task_id;
    logic [1:0]           status;
    logic                 last;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic       latch;
    logic       tick;
    logic [2:0] idx_op;
    logic       wr_en;
    logic       wr_sel;
    logic [1:0] wr_pos;
    logic       head_pop;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       found_set;
    logic       found_clr;
    logic       pend_load;
    logic       burst_clr;
    logic       emit;
    logic       dispatch;
    logic [1:0] status;
    logic       last;
    logic [1:0] id_sel;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic enable;
    logic arg_zero;
    logic full;
    logic empty;
    logic idx_zero;
    logic idx_last;
    logic due_less;
    logic id_match;
    logic head_due;
    logic burst_done;
    logic found;
  } sts_t;

endpackage

>>> design/sorted_deadline_timer_queue.sv
// top level of the sorted deadline timer queue
//
//  channel   handshake                         payload
//  request   start & !busy                     req (cmd, task_id, delay, interval)
//  result    strobe, one cycle, no back-off    rsp (dispatch, out_task_id, status, last)
//  config    cfg_valid & cfg_ready             cfg_index, cfg_data
//
// immediate add/done/remove/tick answers are registered and come in the cycle after the request, without raising busy
// insert walks the ring from the tail, shifting each entry due after the new one up a slot
// remove walks from the head over every entry; tick pops due entries from the head, at most MAX_BURST per tick
// each scan step reads the table through the single read port of the table ram
// rst is synchronous; it clears time, fill count and config, the table contents stay undefined
// results are never stalled; cfg_ready is always high
module sorted_deadline_timer_queue #(
  parameter int DEPTH   = sdtq_pkg::DEPTH_DEF,
  parameter int ID_BITS = sdtq_pkg::ID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  sdtq_pkg::req_t                 req,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sdtq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdtq_pkg::TIME_W-1:0]    cfg_data,
  output logic                           strobe,
  output sdtq_pkg::rsp_t                 rsp
);

  sdtq_pkg::ctl_t ctl;
  sdtq_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  sdtq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (req.cmd),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  sdtq_dpath #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .ctl       (ctl),
    .sts       (sts),
    .strobe    (strobe),
    .rsp       (rsp)
  );

endmodule

>>> design/sdtq_ram.sv
// generic single write port ram with registered read
module sdtq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/sdtq_ctrl.sv
// controller state machine of the sorted deadline timer queue
module sdtq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       cmd,
  input  sdtq_pkg::sts_t   sts,
  output sdtq_pkg::ctl_t   ctl,
  output logic             busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_REM  = 3'd3;
  localparam logic [2:0] S_TICK = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       pend;
  logic       pend_next;

  assign busy = (state != S_IDLE);

  // next state and command decode
  always_comb begin
    ctl        = '0;
    ctl.idx_op = sdtq_pkg::IDX_HOLD;
    ctl.wr_pos = sdtq_pkg::WPOS_IDX;
    ctl.wr_sel = sdtq_pkg::WSEL_NEW;
    ctl.id_sel = sdtq_pkg::IDSEL_CMD;
    ctl.status = sdtq_pkg::ST_OK;
    state_next = state;
    pend_next  = pend;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.latch = 1'b1;
          case (cmd)
            sdtq_pkg::CMD_TICK: begin
              ctl.tick = 1'b1;
              if (!sts.enable) begin
                ctl.emit   = 1'b1;
                ctl.last   = 1'b1;
                ctl.id_sel = sdtq_pkg::IDSEL_ZERO;
              end else begin
                ctl.burst_clr = 1'b1;
                ctl.idx_op    = sdtq_pkg::IDX_LOAD_ZERO;
                pend_next     = 1'b0;
                state_next    = S_TICK;
              end
            end
            sdtq_pkg::CMD_REMOVE: begin
              if (sts.empty) begin
                ctl.emit   = 1'b1;
                ctl.last   = 1'b1;
                ctl.status = sdtq_pkg::ST_NOT_FOUND;
              end else begin
                ctl.idx_op    = sdtq_pkg::IDX_LOAD_ZERO;
                ctl.found_clr = 1'b1;
                state_next    = S_REM;
              end
            end
            default: begin
              // add and done share the insert path
              if (!sts.enable) begin
                ctl.emit   = 1'b1;
                ctl.last   = 1'b1;
                ctl.status = sdtq_pkg::ST_NOT_EN;
              end else if (sts.arg_zero) begin
                ctl.emit     = 1'b1;
                ctl.last     = 1'b1;
                ctl.dispatch = (cmd == sdtq_pkg::CMD_ADD);
              end else if (sts.full) begin
                ctl.emit   = 1'b1;
                ctl.last   = 1'b1;
                ctl.status = sdtq_pkg::ST_FULL;
              end else if (sts.empty) begin
                ctl.idx_op = sdtq_pkg::IDX_LOAD_ZERO;
                state_next = S_PUT;
              end else begin
                ctl.idx_op = sdtq_pkg::IDX_LOAD_TOP;
                state_next = S_INS;
              end
            end
          endcase
        end
      end
      S_INS: begin
        // walk down from the tail, shifting later entries up by one
        ctl.wr_en  = 1'b1;
        ctl.wr_pos = sdtq_pkg::WPOS_P1;
        if (sts.due_less) begin
          ctl.wr_sel = sdtq_pkg::WSEL_OLD;
          if (sts.idx_zero) begin
            state_next = S_PUT;
          end else begin
            ctl.idx_op = sdtq_pkg::IDX_DEC;
          end
        end else begin
          ctl.cnt_inc = 1'b1;
          ctl.emit    = 1'b1;
          ctl.last    = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_PUT: begin
        ctl.wr_en   = 1'b1;
        ctl.cnt_inc = 1'b1;
        ctl.emit    = 1'b1;
        ctl.last    = 1'b1;
        state_next  = S_IDLE;
      end
      S_REM: begin
        // walk up from the head, closing the gap behind the match
        if (sts.found) begin
          ctl.wr_en  = 1'b1;
          ctl.wr_sel = sdtq_pkg::WSEL_OLD;
          ctl.wr_pos = sdtq_pkg::WPOS_M1;
        end else if (sts.id_match) begin
          ctl.found_set = 1'b1;
        end
        if (sts.idx_last) begin
          ctl.emit   = 1'b1;
          ctl.last   = 1'b1;
          state_next = S_IDLE;
          if (sts.found || sts.id_match) begin
            ctl.cnt_dec = 1'b1;
          end else begin
            ctl.status = sdtq_pkg::ST_NOT_FOUND;
          end
        end else begin
          ctl.idx_op = sdtq_pkg::IDX_INC;
        end
      end
      S_TICK: begin
        // hold one dispatch back so the final one can carry last
        if (!sts.empty && !sts.burst_done && sts.head_due) begin
          ctl.head_pop  = 1'b1;
          ctl.pend_load = 1'b1;
          pend_next     = 1'b1;
          if (pend) begin
            ctl.emit     = 1'b1;
            ctl.dispatch = 1'b1;
            ctl.id_sel   = sdtq_pkg::IDSEL_PEND;
          end
        end else begin
          ctl.emit   = 1'b1;
          ctl.last   = 1'b1;
          state_next = S_IDLE;
          if (pend) begin
            ctl.dispatch = 1'b1;
            ctl.id_sel   = sdtq_pkg::IDSEL_PEND;
          end else begin
            ctl.id_sel = sdtq_pkg::IDSEL_ZERO;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

`ifndef SYNTHESIS
  // the block only leaves idle on an accepted request
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted request");

  // a result that is not the last one only comes from a tick burst with a held dispatch
  a_non_last_in_tick: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit && !ctl.last) |-> (state == S_TICK && pend && ctl.dispatch))
    else $error("non-final result outside a tick burst");
`endif

endmodule

>>> design/sdtq_dpath.sv
// datapath of the sorted deadline timer queue: time, table ring, config and result register
module sdtq_dpath #(
  parameter int DEPTH   = sdtq_pkg::DEPTH_DEF,
  parameter int ID_BITS = sdtq_pkg::ID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sdtq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdtq_pkg::TIME_W-1:0]    cfg_data,
  input  sdtq_pkg::req_t                 req,
  input  sdtq_pkg::ctl_t                 ctl,
  output sdtq_pkg::sts_t                 sts,
  output logic                           strobe,
  output sdtq_pkg::rsp_t                 rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int TW = sdtq_pkg::TIME_W;
  localparam int OW = sdtq_pkg::TASK_ID_W;
  localparam int EW = TW + ID_BITS;
  localparam int BW = $clog2(sdtq_pkg::MAX_BURST + 1);

  logic               enable;
  logic [TW-1:0]      min_lead;
  logic [TW-1:0]      now_ms;
  logic [AW-1:0]      head;
  logic [AW-1:0]      head_next;
  logic [CW-1:0]      cnt;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      idx_next;
  logic [ID_BITS-1:0] tid;
  logic [ID_BITS-1:0] tid_cur;
  logic [TW-1:0]      new_due;
  logic               found;
  logic [ID_BITS-1:0] pend_id;
  logic [BW-1:0]      burst;
  logic [AW-1:0]      wpos;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic [EW-1:0]      wdata;
  logic [EW-1:0]      rdata;
  logic [TW-1:0]      rd_due;
  logic [ID_BITS-1:0] rd_id;
  logic [TW-1:0]      rem;

  // logical slot to ring address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // next head and scan index, used to read ahead
  always_comb begin
    head_next = head;
    if (ctl.head_pop) begin
      head_next = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
    end
  end

  always_comb begin
    case (ctl.idx_op)
      sdtq_pkg::IDX_LOAD_TOP:  idx_next = AW'(cnt - CW'(1));
      sdtq_pkg::IDX_LOAD_ZERO: idx_next = '0;
      sdtq_pkg::IDX_INC:       idx_next = idx + 1'b1;
      sdtq_pkg::IDX_DEC:       idx_next = idx - 1'b1;
      default:                 idx_next = idx;
    endcase
  end

  // write position and data
  always_comb begin
    case (ctl.wr_pos)
      sdtq_pkg::WPOS_P1: wpos = idx + 1'b1;
      sdtq_pkg::WPOS_M1: wpos = idx - 1'b1;
      default:           wpos = idx;
    endcase
  end

  assign raddr = phys(head_next, idx_next);
  assign waddr = phys(head, wpos);
  assign wdata = (ctl.wr_sel == sdtq_pkg::WSEL_OLD) ? rdata : {new_due, tid};

  sdtq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_due  = rdata[ID_BITS +: TW];
  assign rd_id   = rdata[ID_BITS-1:0];
  assign rem     = rd_due - now_ms;
  assign tid_cur = ctl.latch ? ID_BITS'(req.task_id) : tid;

  // status toward the controller
  always_comb begin
    sts.enable     = enable;
    sts.arg_zero   = (req.cmd == sdtq_pkg::CMD_DONE) ? (req.interval == '0) : (req.delay == '0);
    sts.full       = (cnt == CW'(DEPTH));
    sts.empty      = (cnt == '0);
    sts.idx_zero   = (idx == '0);
    sts.idx_last   = ((CW'(idx) + CW'(1)) == cnt);
    sts.due_less   = (new_due < rd_due);
    sts.id_match   = (rd_id == tid);
    sts.head_due   = rem[TW-1] || (rem <= min_lead);
    sts.burst_done = (burst == BW'(sdtq_pkg::MAX_BURST));
    sts.found      = found;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable   <= 1'b0;
      min_lead <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sdtq_pkg::CFG_ENABLE:   enable   <= cfg_data[0];
        sdtq_pkg::CFG_MIN_LEAD: min_lead <= cfg_data;
        default:                ;
      endcase
    end
  end

  // time, ring head, fill count, found flag and burst count
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms <= '0;
      head   <= '0;
      cnt    <= '0;
      found  <= 1'b0;
      burst  <= '0;
    end else begin
      if (ctl.tick) begin
        now_ms <= now_ms + 1'b1;
      end
      head <= head_next;
      if (ctl.cnt_inc) begin
        cnt <= cnt + 1'b1;
      end else if (ctl.cnt_dec || ctl.head_pop) begin
        cnt <= cnt - 1'b1;
      end
      if (ctl.found_clr) begin
        found <= 1'b0;
      end else if (ctl.found_set) begin
        found <= 1'b1;
      end
      if (ctl.burst_clr) begin
        burst <= '0;
      end else if (ctl.head_pop) begin
        burst <= burst + 1'b1;
      end
    end
  end

  // request capture, scan index and held dispatch
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (ctl.latch) begin
      tid     <= ID_BITS'(req.task_id);
      new_due <= now_ms + ((req.cmd == sdtq_pkg::CMD_DONE) ? req.interval : req.delay);
    end
    if (ctl.pend_load) begin
      pend_id <= rd_id;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      rsp.dispatch <= ctl.dispatch;
      rsp.status   <= ctl.status;
      rsp.last     <= ctl.last;
      case (ctl.id_sel)
        sdtq_pkg::IDSEL_CMD:  rsp.out_task_id <= OW'(tid_cur);
        sdtq_pkg::IDSEL_PEND: rsp.out_task_id <= OW'(pend_id);
        default:              rsp.out_task_id <= '0;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a new entry is never written into a full table
  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    (ctl.wr_en && ctl.wr_sel == sdtq_pkg::WSEL_NEW) |-> (cnt < CW'(DEPTH)))
    else $error("new entry written into a full table");

  // the head only leaves a non-empty table, and the burst stays bounded
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.head_pop |-> (cnt != '0 && burst < BW'(sdtq_pkg::MAX_BURST)))
    else $error("head popped from an empty table or past the burst limit");
`endif

endmodule

>>> test/tb_sorted_deadline_timer_queue.sv
// testbench of the sorted deadline timer queue: directed and random requests against a predictor
`timescale 1ns / 100ps

module tb_sorted_deadline_timer_queue;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PRINT_LIMIT   = 100;

  typedef struct packed {
    logic [sdtq_pkg::TIME_W-1:0]    due;
    logic [sdtq_pkg::TASK_ID_W-1:0] id;
  } timer_entry_t;

  // random sequence flavors: filling the table, draining it, or mixed churn
  typedef enum int {SEQ_FILL, SEQ_DRAIN, SEQ_CHURN} seq_kind_t;

  // keeps its own copy of the timer table and the answers it predicts
  class deadline_scoreboard_t;
    logic                        enable_q;
    logic [sdtq_pkg::TIME_W-1:0] min_lead_q;
    logic [sdtq_pkg::TIME_W-1:0] now_ms;
    timer_entry_t                timers[$];
    sdtq_pkg::rsp_t              expected_answers[$];
    int unsigned                 fail_count;

    function new();
      enable_q   = 1'b0;
      min_lead_q = '0;
      now_ms     = '0;
      fail_count = 0;
    endfunction

    task report_mismatch(string msg);
      if (fail_count < PRINT_LIMIT) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
      fail_count++;
    endtask

    function void note_register(logic [sdtq_pkg::CFG_IDX_W-1:0] idx,
                                logic [sdtq_pkg::TIME_W-1:0] val);
      if (idx == sdtq_pkg::CFG_ENABLE) begin
        enable_q = val[0];
      end else if (idx == sdtq_pkg::CFG_MIN_LEAD) begin
        min_lead_q = val;
      end
    endfunction

    function void push_answer(logic disp, logic [sdtq_pkg::TASK_ID_W-1:0] id, logic [1:0] st,
                              logic fin);
      sdtq_pkg::rsp_t a;
      a.dispatch    = disp;
      a.out_task_id = id;
      a.status      = st;
      a.last        = fin;
      expected_answers.insert(expected_answers.size(), a);
    endfunction

    // sorted insert after every entry due at or before the new one
    function logic [1:0] insert_timer(logic [sdtq_pkg::TASK_ID_W-1:0] id,
                                      logic [sdtq_pkg::TIME_W-1:0] due);
      int pos;
      timer_entry_t e;
      if (timers.size() >= sdtq_pkg::DEPTH_DEF) return sdtq_pkg::ST_FULL;
      pos = 0;
      while (pos < timers.size() && !(due < timers[pos].due)) pos++;
      e.due = due;
      e.id  = id;
      timers.insert(pos, e);
      return sdtq_pkg::ST_OK;
    endfunction

    // signed remaining time of the head at or below the lead
    function bit head_due();
      logic [sdtq_pkg::TIME_W-1:0] remaining;
      remaining = timers[0].due - now_ms;
      return remaining == 0 || remaining[sdtq_pkg::TIME_W-1] || remaining <= min_lead_q;
    endfunction

    function void note_request(sdtq_pkg::req_t r);
      int             burst;
      bit             found;
      sdtq_pkg::rsp_t tail;
      case (r.cmd)
        sdtq_pkg::CMD_ADD: begin
          if (!enable_q) begin
            push_answer(1'b0, r.task_id, sdtq_pkg::ST_NOT_EN, 1'b1);
          end else if (r.delay == 0) begin
            push_answer(1'b1, r.task_id, sdtq_pkg::ST_OK, 1'b1);
          end else begin
            push_answer(1'b0, r.task_id, insert_timer(r.task_id, now_ms + r.delay), 1'b1);
          end
        end
        sdtq_pkg::CMD_TICK: begin
          now_ms = now_ms + 1;
          burst  = 0;
          while (enable_q && timers.size() > 0 && burst < sdtq_pkg::MAX_BURST &&
                 head_due()) begin
            push_answer(1'b1, timers[0].id, sdtq_pkg::ST_OK, 1'b0);
            timers.delete(0);
            burst++;
          end
          if (burst == 0) begin
            push_answer(1'b0, '0, sdtq_pkg::ST_OK, 1'b1);
          end else begin
            tail      = expected_answers[expected_answers.size() - 1];
            tail.last = 1'b1;
            expected_answers[expected_answers.size() - 1] = tail;
          end
        end
        sdtq_pkg::CMD_REMOVE: begin
          found = 1'b0;
          for (int i = 0; i < timers.size(); i++) begin
            if (!found && timers[i].id == r.task_id) begin
              timers.delete(i);
              found = 1'b1;
            end
          end
          push_answer(1'b0, r.task_id, found ? sdtq_pkg::ST_OK : sdtq_pkg::ST_NOT_FOUND, 1'b1);
        end
        sdtq_pkg::CMD_DONE: begin
          if (!enable_q) begin
            push_answer(1'b0, r.task_id, sdtq_pkg::ST_NOT_EN, 1'b1);
          end else if (r.interval == 0) begin
            push_answer(1'b0, r.task_id, sdtq_pkg::ST_OK, 1'b1);
          end else begin
            push_answer(1'b0, r.task_id, insert_timer(r.task_id, now_ms + r.interval), 1'b1);
          end
        end
      endcase
    endfunction

    task check_answer(sdtq_pkg::rsp_t got);
      sdtq_pkg::rsp_t want;
      if (expected_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result disp %0b id %0d status %0d last %0b",
                                  got.dispatch, got.out_task_id, got.status, got.last));
        return;
      end
      want = expected_answers[0];
      expected_answers.delete(0);
      if (got.dispatch !== want.dispatch || got.out_task_id !== want.out_task_id ||
          got.status !== want.status || got.last !== want.last) begin
        report_mismatch($sformatf(
          "got disp %0b id %0d status %0d last %0b, want disp %0b id %0d status %0d last %0b",
          got.dispatch, got.out_task_id, got.status, got.last,
          want.dispatch, want.out_task_id, want.status, want.last));
      end
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           start;
  logic                           busy;
  sdtq_pkg::req_t                 req;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [sdtq_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sdtq_pkg::TIME_W-1:0]    cfg_data;
  logic                           strobe;
  sdtq_pkg::rsp_t                 rsp;

  deadline_scoreboard_t book;
  int                   idle_pct;
  int                   cycle_count = 0;

  sorted_deadline_timer_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .strobe    (strobe),
    .rsp       (rsp)
  );

  always #HALF_PERIOD clk = ~clk;

  // results cannot be held off, so every strobe is checked as it comes
  always @(posedge clk) begin
    if (!rst && strobe) begin
      book.check_answer(rsp);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // one request; start stays high from the last acceptance unless a gap is drawn
  task automatic send_request(input sdtq_pkg::req_t r);
    logic [95:0] junk;
    @(negedge clk);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      junk  = {$urandom(), $urandom(), $urandom()};
      req   = junk[$bits(sdtq_pkg::req_t)-1:0];
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
    start = 1'b1;
    req   = r;
    do @(posedge clk); while (busy);
    book.note_request(r);
  endtask

  task automatic write_register(input logic [sdtq_pkg::CFG_IDX_W-1:0] idx,
                                input logic [sdtq_pkg::TIME_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    book.note_register(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // stop requests and let every predicted answer come back
  task automatic settle_queue();
    @(negedge clk);
    start = 1'b0;
    while (book.expected_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic sdtq_pkg::req_t make_request(logic [1:0] cmd,
                                                  logic [sdtq_pkg::TASK_ID_W-1:0] id,
                                                  logic [sdtq_pkg::TIME_W-1:0] delay,
                                                  logic [sdtq_pkg::TIME_W-1:0] interval);
    sdtq_pkg::req_t r;
    r.cmd      = cmd;
    r.task_id  = id;
    r.delay    = delay;
    r.interval = interval;
    return r;
  endfunction

  // mostly short spans, with zero, full random and wrapping values mixed in
  function automatic logic [sdtq_pkg::TIME_W-1:0] random_span(int zero_pct);
    int pick;
    pick = $urandom_range(99);
    if (pick < zero_pct) return '0;
    if (pick < zero_pct + 8) return $urandom();
    if (pick < zero_pct + 12) return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
    return 32'($urandom_range(1, 12));
  endfunction

  function automatic sdtq_pkg::req_t random_request(seq_kind_t kind);
    sdtq_pkg::req_t r;
    int             pick;
    pick = $urandom_range(99);
    case (kind)
      SEQ_FILL: begin
        r.cmd = pick < 70 ? sdtq_pkg::CMD_ADD : pick < 82 ? sdtq_pkg::CMD_DONE :
                pick < 92 ? sdtq_pkg::CMD_TICK : sdtq_pkg::CMD_REMOVE;
      end
      SEQ_DRAIN: begin
        r.cmd = pick < 60 ? sdtq_pkg::CMD_TICK : pick < 75 ? sdtq_pkg::CMD_REMOVE :
                pick < 88 ? sdtq_pkg::CMD_ADD : sdtq_pkg::CMD_DONE;
      end
      default: begin
        r.cmd = pick < 25 ? sdtq_pkg::CMD_ADD : pick < 50 ? sdtq_pkg::CMD_TICK :
                pick < 75 ? sdtq_pkg::CMD_REMOVE : sdtq_pkg::CMD_DONE;
      end
    endcase
    // a small id pool so removes hit and duplicates occur
    r.task_id  = ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(15));
    r.delay    = random_span(8);
    r.interval = random_span(15);
    return r;
  endfunction

  task automatic run_phase(input logic en, input logic [sdtq_pkg::TIME_W-1:0] lead,
                           input int idle, input int count);
    seq_kind_t kind;
    int        left;
    int        sent;
    settle_queue();
    write_register(sdtq_pkg::CFG_ENABLE, {31'b0, en});
    write_register(sdtq_pkg::CFG_MIN_LEAD, lead);
    idle_pct = idle;
    sent     = 0;
    while (sent < count) begin
      kind = seq_kind_t'($urandom_range(2));
      left = $urandom_range(5, 20);
      while (left > 0 && sent < count) begin
        send_request(random_request(kind));
        left--;
        sent++;
      end
    end
  endtask

  initial begin
    book      = new();
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_pct  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // disabled after reset: adds and re-arms rejected, remove misses, tick only advances time
    send_request(make_request(sdtq_pkg::CMD_ADD, 8'h5A, 32'd5, 32'd0));
    send_request(make_request(sdtq_pkg::CMD_DONE, 8'hA5, 32'd0, 32'd9));
    send_request(make_request(sdtq_pkg::CMD_DONE, 8'h01, 32'd0, 32'd0));
    send_request(make_request(sdtq_pkg::CMD_REMOVE, 8'h03, 32'd0, 32'd0));
    send_request(make_request(sdtq_pkg::CMD_TICK, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

    settle_queue();
    write_register(sdtq_pkg::CFG_ENABLE, 32'd1);
    write_register(sdtq_pkg::CFG_MIN_LEAD, 32'd0);

    // immediate dispatch, wrapped and signed-boundary due times, duplicates, one-shot done
    send_request(make_request(sdtq_pkg::CMD_ADD, 8'hFF, 32'd0, 32'd0));
    send_request(make_request(sdtq_pkg::CMD_ADD, 8'h00, 32'hFFFF_FFFF, 32'd0));
    send_request(make_request(sdtq_pkg::CMD_ADD, 8'h01, 32'd2, 32'd0));
    send_request(make_request(sdtq_pkg::CMD_ADD, 8'h01, 32'd2, 32'd0));
    send_request(make_request(sdtq_pkg::CMD_ADD, 8'h02, 32'h8000_0000, 32'd0));
    send_request(make_request(sdtq_pkg::CMD_DONE, 8'h07, 32'd0, 32'd0));
    send_request(make_request(sdtq_pkg::CMD_DONE, 8'h07, 32'd0, 32'd3));
    send_request(make_request(sdtq_pkg::CMD_REMOVE, 8'h01, 32'd0, 32'd0));
    send_request(make_request(sdtq_pkg::CMD_REMOVE, 8'h63, 32'd0, 32'd0));
    repeat (4) send_request(make_request(sdtq_pkg::CMD_TICK, 8'h00, 32'd0, 32'd0));

    // random phases over register settings and sender gaps
    run_phase(1'b1, 32'd0, 0, 90);
    run_phase(1'b1, 32'd3, 61, 90);
    run_phase(1'b0, 32'hFFFF_FFFF, 22, 40);
    run_phase(1'b1, 32'hFFFF_FFFF, 0, 50);
    run_phase(1'b1, 32'($urandom_range(0, 40)), 61, 60);
    run_phase(1'b1, 32'h7FFF_FFFF, 22, 40);
    run_phase(1'b1, 32'd1, 0, 100);

    settle_queue();
    if (book.fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
design/sdtq_pkg.sv
design/sdtq_ram.sv
design/sdtq_ctrl.sv
design/sdtq_dpath.sv
design/sorted_deadline_timer_queue.sv
test/tb_sorted_deadline_timer_queue.sv
